[rtl/skt_pkg.sv]
// Shared types and codes for the sorted key table.
package skt_pkg;

	localparam int KEY_W     = 32;
	localparam int PAYLOAD_W = 64;
	localparam int ENTRY_W   = KEY_W + PAYLOAD_W;
	localparam int STATUS_W  = 2;
	localparam int OUT_USER_W = STATUS_W + 1;

	localparam logic ACTION_INSERT = 1'b0;
	localparam logic ACTION_SCAN   = 1'b1;

	localparam logic [STATUS_W-1:0] ST_SUCCESS   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_UNUSED    = 2'd3;

	typedef struct packed {
		logic [PAYLOAD_W-1:0] payload;
		logic [KEY_W-1:0]     key;
	} entry_t;

	typedef struct packed {
		logic                row_valid;
		logic [STATUS_W-1:0] status;
	} out_user_t;

endpackage

[rtl/sorted_key_table.sv]
// Sorted key table: RAM-backed sorted array with binary search insert and ordered scan.
//
// Input channel s_*: one word per command. s_tuser is the action (insert or scan),
// s_tdata carries key and payload. Output channel m_*: result words; m_tuser holds
// status and row_valid, m_tdata holds the scanned key and payload, m_tlast marks the
// final result word of a command.
// An insert gives one status word. It accepts the command, runs binary search probes
// (at most log2(entries)+1), each a RAM read and then a compare, closes the search,
// shifts each larger entry up with a read and a write, writes the new entry and hands
// the word to the output register. A full table answers with a full status word and
// no search. A scan gives one word per stored entry, each read through the single RAM
// read port before it is sent; the next entry is read once the output register takes
// the word. An empty table gives one word with row_valid low.
// Commands are handled one at a time; s_tready is high only between commands and
// may rise while the last result word still waits in the output register.
// When the receiver stalls, the output register holds its word and the sequencer
// waits before producing the next one.
// Reset empties the table at once (entry count to zero); the RAM needs no clearing.
module sorted_key_table
	import skt_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [ENTRY_W-1:0] s_tdata,   // key[31:0], payload[95:32]
	input  logic               s_tuser,   // action
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [ENTRY_W-1:0] m_tdata,   // out_key[31:0], out_payload[95:32]
	output logic [OUT_USER_W-1:0] m_tuser, // status[1:0], row_valid[2]
	output logic               m_tlast
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SEARCH   = 3'd1;
	localparam logic [2:0] S_SWAIT    = 3'd2;
	localparam logic [2:0] S_SHIFT_RD = 3'd3;
	localparam logic [2:0] S_SHIFT_WR = 3'd4;
	localparam logic [2:0] S_EMIT     = 3'd5;
	localparam logic [2:0] S_SCAN_RD  = 3'd6;
	localparam logic [2:0] S_SCAN_OUT = 3'd7;

	logic [2:0]          state_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       lo_q;
	logic [CW-1:0]       hi_q;
	logic [CW-1:0]       i_q;
	logic [AW-1:0]       mid_q;
	logic [STATUS_W-1:0] status_q;
	logic [KEY_W-1:0]    key_q;
	logic [PAYLOAD_W-1:0] payload_q;

	logic                m_tvalid_q;
	logic [ENTRY_W-1:0]  m_tdata_q;
	out_user_t           m_tuser_q;
	logic                m_tlast_q;

	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	entry_t              wr_data;
	entry_t              rd_data;

	logic                out_free;
	logic                out_load;
	logic [CW:0]         mid_sum;
	logic [CW-1:0]       mid_w;
	logic                scan_last;
	logic                accept;

	assign out_free  = !m_tvalid_q || m_tready;
	assign out_load  = out_free && (state_q == S_EMIT || state_q == S_SCAN_OUT);
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_w     = mid_sum[CW:1];
	assign scan_last = ((i_q + CW'(1)) == count_q);
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;

	skt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = mid_w[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = i_q[AW-1:0];
		wr_data = rd_data;
		unique case (state_q)
			S_SEARCH: begin
				rd_en   = (lo_q != hi_q);
				rd_addr = mid_w[AW-1:0];
			end
			S_SHIFT_RD: begin
				if (i_q == lo_q) begin
					wr_en   = 1'b1;
					wr_addr = lo_q[AW-1:0];
					wr_data = '{payload: payload_q, key: key_q};
				end else begin
					rd_en   = 1'b1;
					rd_addr = AW'(i_q - CW'(1));
				end
			end
			S_SHIFT_WR: begin
				wr_en   = 1'b1;
				wr_addr = i_q[AW-1:0];
				wr_data = rd_data;
			end
			S_SCAN_RD: begin
				rd_en   = 1'b1;
				rd_addr = i_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			m_tvalid_q <= out_load || (m_tvalid_q && !m_tready);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (s_tuser == ACTION_SCAN) begin
							state_q <= (count_q == '0) ? S_EMIT : S_SCAN_RD;
						end else if (count_q == CAP_C) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					state_q <= (lo_q == hi_q) ? S_SHIFT_RD : S_SWAIT;
				end
				S_SWAIT: begin
					state_q <= (key_q == rd_data.key) ? S_EMIT : S_SEARCH;
				end
				S_SHIFT_RD: begin
					if (i_q == lo_q) begin
						count_q <= count_q + CW'(1);
						state_q <= S_EMIT;
					end else begin
						state_q <= S_SHIFT_WR;
					end
				end
				S_SHIFT_WR: begin
					state_q <= S_SHIFT_RD;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_OUT;
				end
				S_SCAN_OUT: begin
					if (out_free) begin
						state_q <= scan_last ? S_IDLE : S_SCAN_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				key_q     <= s_tdata[KEY_W-1:0];
				payload_q <= s_tdata[ENTRY_W-1:KEY_W];
				lo_q      <= '0;
				hi_q      <= count_q;
				i_q       <= '0;
				status_q  <= (s_tuser == ACTION_INSERT && count_q == CAP_C) ? ST_FULL
					: ST_SUCCESS;
			end
			S_SEARCH: begin
				mid_q <= mid_w[AW-1:0];
				i_q   <= count_q;
			end
			S_SWAIT: begin
				if (key_q == rd_data.key) begin
					status_q <= ST_DUPLICATE;
				end else if (key_q < rd_data.key) begin
					hi_q <= CW'(mid_q);
				end else begin
					lo_q <= CW'(mid_q) + CW'(1);
				end
			end
			S_SHIFT_WR: begin
				i_q <= i_q - CW'(1);
			end
			S_EMIT: begin
				if (out_free) begin
					m_tdata_q <= '0;
					m_tuser_q <= '{row_valid: 1'b0, status: status_q};
					m_tlast_q <= 1'b1;
				end
			end
			S_SCAN_OUT: begin
				if (out_free) begin
					m_tdata_q <= rd_data;
					m_tuser_q <= '{row_valid: 1'b1, status: ST_SUCCESS};
					m_tlast_q <= scan_last;
					i_q       <= i_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

[rtl/skt_ram.sv]
// Generic simple dual-port RAM with registered read.
module skt_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/skt_checker.sv]
// Port-level assertions for the sorted key table, bound to the top level.
module skt_checker
	import skt_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [ENTRY_W-1:0]    m_tdata,
	input logic [OUT_USER_W-1:0] m_tuser,
	input logic                  m_tlast
);

	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready did not drop after a command word");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output word changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[STATUS_W-1:0] != ST_UNUSED)
		else $error("undefined status code");

	a_norow_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[STATUS_W] |-> m_tlast && m_tdata == '0)
		else $error("status word must be last and carry no row");

	a_row_success: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[STATUS_W] |-> m_tuser[STATUS_W-1:0] == ST_SUCCESS)
		else $error("scanned row with failure status");

endmodule

bind sorted_key_table skt_checker u_skt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser),
	.m_tlast(m_tlast)
);
